/* hw/rtl/cba_pkg.sv */
// cba_pkg: constants, field widths and types of the contiguous block allocator
// used by the channel interfaces and by contiguous_block_allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    // map storage
    localparam int MAX_BLOCKS = 1024;
    localparam int MAP_AW     = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // field widths
    localparam int REQ_TYPE_W    = 1;
    localparam int BLOCK_IDX_W   = 10;
    localparam int BYTE_COUNT_W  = 27;
    localparam int FIRST_BLOCK_W = 10;
    localparam int NEEDED_W      = 11;
    localparam int BLOCK_SIZE_W  = 17;
    localparam int IN_USE_W      = 11;

    // block counts and indexes inside the scan
    localparam int IDX_W = (CNT_W > IN_USE_W) ? CNT_W : IN_USE_W;

    // ceiling division: dividend is byte_count + block_size - 1
    localparam int DIV_W  = 28;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam logic [NEEDED_W-1:0] NEED_CAP = NEEDED_W'(1025);

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_SET   = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BLOCK_SIZE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = BLOCK_SIZE_W'(1024);
    localparam logic [IN_USE_W-1:0]     IN_USE_RST     = IN_USE_W'(1024);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

endpackage : cba_pkg

`default_nettype wire

/* hw/rtl/cba_req_if.sv */
// cba_req_if: request channel of the allocator (set or allocate items)
// depends on cba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cba_req_if;
    import cba_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [BLOCK_IDX_W-1:0]   block_index;
    logic                     block_used;
    logic [BYTE_COUNT_W-1:0]  byte_count;

    modport source (
        output valid, req_type, block_index, block_used, byte_count,
        input  ready
    );

    modport sink (
        input  valid, req_type, block_index, block_used, byte_count,
        output ready
    );

endinterface : cba_req_if

`default_nettype wire

/* hw/rtl/cba_rsp_if.sv */
// cba_rsp_if: result channel of the allocator
// depends on cba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cba_rsp_if;
    import cba_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [FIRST_BLOCK_W-1:0]  first_block;
    logic [NEEDED_W-1:0]       blocks_needed;

    modport source (
        output valid, found, first_block, blocks_needed,
        input  ready
    );

    modport sink (
        input  valid, found, first_block, blocks_needed,
        output ready
    );

endinterface : cba_rsp_if

`default_nettype wire

/* hw/rtl/cba_cfg_if.sv */
// cba_cfg_if: register write channel of the allocator
// depends on cba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cba_cfg_if;
    import cba_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface : cba_cfg_if

`default_nettype wire

/* hw/rtl/contiguous_block_allocator.sv */
// contiguous_block_allocator: first-fit allocator over a one-bit used map
// depends on cba_pkg, cba_req_if, cba_rsp_if, cba_cfg_if
`timescale 1ns / 1ps
`default_nettype none

// The used map is one flag per volume block held in a single-port-write,
// registered-read memory. After reset a clearing pass writes every entry
// free, one per cycle, during which no item is taken; register writes are
// accepted throughout. A set item writes one flag; it produces no result.
// An allocate item first runs a one-bit-per-cycle restoring divider for the
// ceiling of bytes over block size (skipped when block size is zero), then,
// if the map is large enough, streams the map through the memory read port
// one entry per cycle: it skips the first free block (kept for the file
// header) and stops at the first run of free blocks of the needed length or
// at the end of the map. The result sits in an output register, so set
// items are taken while it waits to be read.

module contiguous_block_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cba_req_if.sink    i_req,
    cba_rsp_if.source  o_rsp,
    cba_cfg_if.sink    i_cfg
);
    import cba_pkg::*;

    // control
    t_state                  r_state;
    logic [MAP_AW-1:0]       r_clr_addr;

    // configuration registers
    logic [BLOCK_SIZE_W-1:0] r_block_size;
    logic [IN_USE_W-1:0]     r_blocks_in_use;

    // divider
    logic [DIV_W-1:0]        r_dvd;      // dividend, shifts into quotient
    logic [BLOCK_SIZE_W-1:0] r_rem;
    logic [DCNT_W-1:0]       r_div_cnt;
    logic                    r_unbnd;

    // scan
    logic [IDX_W-1:0]        r_n;        // map length, clamped to storage
    logic [IDX_W-1:0]        r_scan_addr;
    logic [IDX_W-1:0]        r_chk_idx;
    logic                    r_chk_vld;
    logic                    r_hdr;      // header block already skipped
    logic [IDX_W-1:0]        r_run;
    logic [IDX_W-1:0]        r_start;
    logic                    r_found;

    // result register
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [FIRST_BLOCK_W-1:0] r_out_first;
    logic [NEEDED_W-1:0]      r_out_needed;

    // map memory
    logic                    r_map [MAX_BLOCKS];
    logic                    r_rd_data;
    logic                    mem_we;
    logic [MAP_AW-1:0]       mem_wa;
    logic                    mem_wd;
    logic [MAP_AW-1:0]       mem_ra;

    logic                    in_acc;
    logic                    set_ok;
    logic [IDX_W-1:0]        n_clamped;

    // divider step
    logic [BLOCK_SIZE_W:0]   div_trial;
    logic                    div_ge;
    logic [BLOCK_SIZE_W-1:0] div_rem_nx;
    logic [DIV_W-1:0]        div_q_nx;
    logic                    scan_ok;

    // scan step
    logic [IDX_W-1:0]        run_inc;
    logic                    run_hit;
    logic                    scan_last;

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found         = r_out_found;
    assign o_rsp.first_block   = r_out_first;
    assign o_rsp.blocks_needed = r_out_needed;

    // set items beyond the storage are dropped
    assign set_ok    = (32'(i_req.block_index) < MAX_BLOCKS);
    assign n_clamped = (32'(r_blocks_in_use) > MAX_BLOCKS) ? IDX_W'(MAX_BLOCKS)
                                                           : IDX_W'(r_blocks_in_use);

    // restoring division, one quotient bit per cycle
    assign div_trial  = {r_rem, r_dvd[DIV_W-1]};
    assign div_ge     = (div_trial >= {1'b0, r_block_size});
    assign div_rem_nx = div_ge ? BLOCK_SIZE_W'(div_trial - {1'b0, r_block_size})
                               : BLOCK_SIZE_W'(div_trial);
    assign div_q_nx   = {r_dvd[DIV_W-2:0], div_ge};
    // map must hold at least needed + 2 blocks, and zero bytes never fit
    assign scan_ok    = (div_q_nx != '0) &&
                        ({1'b0, DIV_W'(r_n)} >= ({1'b0, div_q_nx} + (DIV_W+1)'(2)));

    assign run_inc   = r_run + IDX_W'(1);
    assign run_hit   = (DIV_W'(run_inc) == r_dvd);
    assign scan_last = (r_chk_idx == (r_n - IDX_W'(1)));

    // memory port selection: clearing pass or set item on the write side
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_addr;
        mem_wd = 1'b0;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_acc && (i_req.req_type == REQ_SET) && set_ok) begin
            mem_we = 1'b1;
            mem_wa = MAP_AW'(i_req.block_index);
            mem_wd = i_req.block_used;
        end
    end

    assign mem_ra = MAP_AW'(r_scan_addr);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_map[mem_ra];
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size    <= BLOCK_SIZE_RST;
            r_blocks_in_use <= IN_USE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == CFG_BLOCK_SIZE) begin
                r_block_size <= i_cfg.data;
            end else begin
                r_blocks_in_use <= i_cfg.data[IN_USE_W-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken, unless a new one is loaded in the same cycle
            if (o_rsp.valid && o_rsp.ready && (r_state != ST_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + MAP_AW'(1);
                    if (r_clr_addr == MAP_AW'(MAX_BLOCKS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (in_acc && (i_req.req_type == REQ_ALLOC)) begin
                        r_n       <= n_clamped;
                        r_rem     <= '0;
                        r_div_cnt <= DCNT_W'(DIV_W - 1);
                        r_found   <= 1'b0;
                        r_dvd     <= DIV_W'(i_req.byte_count) + DIV_W'(r_block_size)
                                     - DIV_W'(1);
                        if (r_block_size == '0) begin
                            // no block size: count is unbounded, fails at once
                            r_unbnd <= 1'b1;
                            r_state <= ST_RESULT;
                        end else begin
                            r_unbnd <= 1'b0;
                            r_state <= ST_DIV;
                        end
                    end
                end

                ST_DIV: begin
                    r_dvd     <= div_q_nx;
                    r_rem     <= div_rem_nx;
                    r_div_cnt <= r_div_cnt - DCNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_scan_addr <= '0;
                        r_chk_vld   <= 1'b0;
                        r_hdr       <= 1'b0;
                        r_run       <= '0;
                        r_state     <= scan_ok ? ST_SCAN : ST_RESULT;
                    end
                end

                ST_SCAN: begin
                    // issue one read a cycle, check the entry read last cycle
                    if (r_scan_addr != r_n) begin
                        r_scan_addr <= r_scan_addr + IDX_W'(1);
                    end
                    r_chk_vld <= (r_scan_addr != r_n);
                    r_chk_idx <= r_scan_addr;
                    if (r_chk_vld) begin
                        if (!r_hdr) begin
                            // first free block is the header: skip it
                            if (!r_rd_data) begin
                                r_hdr <= 1'b1;
                            end
                        end else if (r_rd_data) begin
                            r_run <= '0;
                        end else begin
                            r_run <= run_inc;
                            if (r_run == '0) begin
                                r_start <= r_chk_idx;
                            end
                            if (run_hit) begin
                                r_found <= 1'b1;
                                if (r_run != '0) begin
                                    r_start <= r_start;
                                end
                            end
                        end
                        if ((r_hdr && !r_rd_data && run_hit) || scan_last) begin
                            r_state <= ST_RESULT;
                        end
                    end
                end

                ST_RESULT: begin
                    // wait for a free output register
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_first <= r_found ? FIRST_BLOCK_W'(r_start) : '0;
                        if (r_unbnd || (r_dvd > DIV_W'(NEED_CAP))) begin
                            r_out_needed <= NEED_CAP;
                        end else begin
                            r_out_needed <= r_dvd[NEEDED_W-1:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // no set item may reach the map while an allocation is in flight
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_DIV) |-> !mem_we)
        else $error("map written during allocation");

    // a scan only starts with a non-zero block count
    a_scan_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SCAN) |-> (r_dvd != '0))
        else $error("scan started with zero block count");

    // a found run never starts at block zero, the header precedes it
    a_found_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_first != '0))
        else $error("run starts on the header block");

    // no item taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready)
        else $error("item taken during clearing pass");

    // a failed result reports first block zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && !r_found && (!r_out_valid || o_rsp.ready))
        |=> (o_rsp.valid && o_rsp.first_block == '0))
        else $error("failed result with non-zero first block");

endmodule : contiguous_block_allocator

`default_nettype wire
